// ===== sv/segment_intersection_test_unit_defines.svh =====
// assertion macros for the segment intersection test unit
// used by the top level only, no other dependencies
`ifndef SEGMENT_INTERSECTION_TEST_UNIT_DEFINES_SVH
`define SEGMENT_INTERSECTION_TEST_UNIT_DEFINES_SVH

// same-cycle implication
`define SIT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SIT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/sit_pkg.sv =====
// shared types, constants and saturating q32.32 helpers
// no dependencies; imported by the divider, multiplier and top level
`timescale 1ns / 1ps
`default_nettype none

package sit_pkg;

    localparam int Q_W       = 64;
    localparam int QUOT_FRAC = 32;
    localparam int MUL_LAT   = 4;
    localparam int TOL_W     = 16;
    localparam int MARGIN_W  = 18;
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;

    localparam logic [TOL_W-1:0]           TOL_RESET    = 16'd1;
    localparam logic signed [MARGIN_W-1:0] MARGIN_RESET = -18'sd1;

    localparam logic signed [Q_W-1:0] W_MAX = 64'sh7fff_ffff_ffff_ffff;
    localparam logic signed [Q_W-1:0] W_MIN = 64'sh8000_0000_0000_0000;

    typedef enum logic [0:0] {
        REG_TOL    = 1'b0,
        REG_MARGIN = 1'b1
    } reg_idx_t;

    typedef enum logic [1:0] {
        CASE_GENERAL     = 2'd0,
        CASE_FIRST_VERT  = 2'd1,
        CASE_SECOND_VERT = 2'd2
    } case_code_t;

    function automatic logic signed [Q_W-1:0] sat_add(input logic signed [Q_W-1:0] a,
                                                      input logic signed [Q_W-1:0] b);
        logic [Q_W:0] t;
        logic signed [Q_W-1:0] r;
        t = {a[Q_W-1], a} + {b[Q_W-1], b};
        if (t[Q_W] != t[Q_W-1])
        begin
            r = t[Q_W] ? W_MIN : W_MAX;
        end
        else
        begin
            r = $signed(t[Q_W-1:0]);
        end
        return r;
    endfunction

    function automatic logic signed [Q_W-1:0] sat_sub(input logic signed [Q_W-1:0] a,
                                                      input logic signed [Q_W-1:0] b);
        logic [Q_W:0] t;
        logic signed [Q_W-1:0] r;
        t = {a[Q_W-1], a} - {b[Q_W-1], b};
        if (t[Q_W] != t[Q_W-1])
        begin
            r = t[Q_W] ? W_MIN : W_MAX;
        end
        else
        begin
            r = $signed(t[Q_W-1:0]);
        end
        return r;
    endfunction

    function automatic logic signed [Q_W-1:0] from_mag(input logic [Q_W-1:0] m,
                                                       input logic neg, input logic ovf);
        logic signed [Q_W-1:0] r;
        if (neg)
        begin
            if (ovf || (m[Q_W-1] && (|m[Q_W-2:0])))
            begin
                r = W_MIN;
            end
            else
            begin
                r = $signed({Q_W{1'b0}} - m);
            end
        end
        else
        begin
            if (ovf || m[Q_W-1])
            begin
                r = W_MAX;
            end
            else
            begin
                r = $signed(m);
            end
        end
        return r;
    endfunction

    function automatic logic signed [Q_W-1:0] abs_sat(input logic signed [Q_W-1:0] v);
        logic signed [Q_W-1:0] r;
        if (v == W_MIN)
        begin
            r = W_MAX;
        end
        else if (v[Q_W-1])
        begin
            r = -v;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/sit_div.sv =====
// pipelined restoring divider, (num << 32) / den, one quotient bit per stage
// saturating q32.32 result; depends on sit_pkg
`timescale 1ns / 1ps
`default_nettype none

module sit_div #(
    parameter int IW    = 33,
    parameter int TAG_W = 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic signed [IW-1:0] num,
    input  logic signed [IW-1:0] den,
    input  logic [TAG_W-1:0]     in_tag,
    output logic                 out_valid,
    output logic signed [63:0]   quot,
    output logic [TAG_W-1:0]     out_tag
);
    import sit_pkg::*;

    localparam int NSTEP = IW + QUOT_FRAC;

    logic [NSTEP:0]       v_reg;
    logic [NSTEP-1:0]     nx_reg  [0:NSTEP];
    logic [IW-1:0]        md_reg  [0:NSTEP];
    logic [IW-1:0]        r_reg   [0:NSTEP];
    logic [Q_W-1:0]       q_reg   [0:NSTEP];
    logic                 ovf_reg [0:NSTEP];
    logic                 neg_reg [0:NSTEP];
    logic [TAG_W-1:0]     tag_reg [0:NSTEP];

    logic [IW-1:0] nu;
    logic [IW-1:0] du;
    logic [IW-1:0] mn;
    logic [IW-1:0] md;

    assign nu = num;
    assign du = den;
    assign mn = nu[IW-1] ? (~nu + {{(IW-1){1'b0}}, 1'b1}) : nu;
    assign md = du[IW-1] ? (~du + {{(IW-1){1'b0}}, 1'b1}) : du;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[NSTEP-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        nx_reg[0]  <= {mn, {QUOT_FRAC{1'b0}}};
        md_reg[0]  <= md;
        r_reg[0]   <= '0;
        q_reg[0]   <= '0;
        ovf_reg[0] <= 1'b0;
        neg_reg[0] <= nu[IW-1] ^ du[IW-1];
        tag_reg[0] <= in_tag;
    end

    for (genvar k = 0; k < NSTEP; k++)
    begin : g_step
        localparam int I = NSTEP - 1 - k;
        logic [IW:0] rs;
        logic        ge;
        logic [IW:0] rn;

        assign rs = {r_reg[k], nx_reg[k][I]};
        assign ge = (rs >= {1'b0, md_reg[k]});
        assign rn = ge ? (rs - {1'b0, md_reg[k]}) : rs;

        always_ff @(posedge clk)
        begin
            nx_reg[k+1]  <= nx_reg[k];
            md_reg[k+1]  <= md_reg[k];
            r_reg[k+1]   <= rn[IW-1:0];
            q_reg[k+1]   <= q_reg[k] | ({{(Q_W-1){1'b0}}, ge} << I);
            ovf_reg[k+1] <= ovf_reg[k] | (ge & (I >= Q_W));
            neg_reg[k+1] <= neg_reg[k];
            tag_reg[k+1] <= tag_reg[k];
        end
    end

    assign out_valid = v_reg[NSTEP];
    assign quot      = from_mag(q_reg[NSTEP], neg_reg[NSTEP], ovf_reg[NSTEP]);
    assign out_tag   = tag_reg[NSTEP];

endmodule

`default_nettype wire

// ===== sv/sit_mul.sv =====
// four-stage signed multiplier, (a * b) >> SH toward zero, saturated to 64 bits
// built from 32x32 partial products; depends on sit_pkg
`timescale 1ns / 1ps
`default_nettype none

module sit_mul #(
    parameter int AW    = 32,
    parameter int SH    = 16,
    parameter int TAG_W = 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic signed [AW-1:0] a,
    input  logic signed [63:0]   b,
    input  logic [TAG_W-1:0]     in_tag,
    output logic                 out_valid,
    output logic signed [63:0]   res,
    output logic [TAG_W-1:0]     out_tag
);
    import sit_pkg::*;

    logic [MUL_LAT-1:0] v_reg;
    logic [Q_W-1:0]     ma_reg;
    logic [Q_W-1:0]     mb_reg;
    logic               neg_reg [0:MUL_LAT-1];
    logic [TAG_W-1:0]   tag_reg [0:MUL_LAT-1];
    logic [Q_W-1:0]     p00_reg;
    logic [Q_W-1:0]     p01_reg;
    logic [Q_W-1:0]     p10_reg;
    logic [Q_W-1:0]     p11_reg;
    logic [2*Q_W-1:0]   prod_reg;
    logic signed [Q_W-1:0] res_reg;

    logic [Q_W-1:0]   ax;
    logic [Q_W-1:0]   bx;
    logic [Q_W-1:0]   ma_next;
    logic [Q_W-1:0]   mb_next;
    logic [2*Q_W-1:0] shifted;

    assign ax      = {{(Q_W-AW){a[AW-1]}}, a};
    assign bx      = b;
    assign ma_next = ax[Q_W-1] ? ({Q_W{1'b0}} - ax) : ax;
    assign mb_next = bx[Q_W-1] ? ({Q_W{1'b0}} - bx) : bx;
    assign shifted = prod_reg >> SH;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[MUL_LAT-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        ma_reg     <= ma_next;
        mb_reg     <= mb_next;
        neg_reg[0] <= ax[Q_W-1] ^ bx[Q_W-1];
        tag_reg[0] <= in_tag;

        p00_reg <= ma_reg[31:0]  * mb_reg[31:0];
        p01_reg <= ma_reg[31:0]  * mb_reg[63:32];
        p10_reg <= ma_reg[63:32] * mb_reg[31:0];
        p11_reg <= ma_reg[63:32] * mb_reg[63:32];

        prod_reg <= {{Q_W{1'b0}}, p00_reg}
                  + {32'd0, p01_reg, 32'd0}
                  + {32'd0, p10_reg, 32'd0}
                  + {p11_reg, {Q_W{1'b0}}};

        res_reg <= from_mag(shifted[Q_W-1:0], neg_reg[2], |shifted[2*Q_W-1:Q_W]);

        for (int s = 1; s < MUL_LAT; s++)
        begin
            neg_reg[s] <= neg_reg[s-1];
            tag_reg[s] <= tag_reg[s-1];
        end
    end

    assign out_valid = v_reg[MUL_LAT-1];
    assign res       = res_reg;
    assign out_tag   = tag_reg[MUL_LAT-1];

endmodule

`default_nettype wire

// ===== sv/segment_intersection_test_unit.sv =====
// throughput: one segment pair per cycle, busy stays low, done words cannot be held off
// the latency is dominated by two bit-per-stage dividers (slope, then crossing x)
// reset clears all valid bits; vertical_tolerance resets to 1, edge_margin to -1
// top level of the segment intersection test; uses sit_pkg, sit_div, sit_mul
`timescale 1ns / 1ps
`default_nettype none
`include "segment_intersection_test_unit_defines.svh"

module segment_intersection_test_unit #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [sit_pkg::ADDR_W-1:0]        paddr,
    input  logic [sit_pkg::DATA_W-1:0]        pwdata,
    output logic [sit_pkg::DATA_W-1:0]        prdata,
    output logic                              pready,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [COORD_WIDTH-1:0]     first_x1,
    input  logic signed [COORD_WIDTH-1:0]     first_y1,
    input  logic signed [COORD_WIDTH-1:0]     first_x2,
    input  logic signed [COORD_WIDTH-1:0]     first_y2,
    input  logic signed [COORD_WIDTH-1:0]     second_x1,
    input  logic signed [COORD_WIDTH-1:0]     second_y1,
    input  logic signed [COORD_WIDTH-1:0]     second_x2,
    input  logic signed [COORD_WIDTH-1:0]     second_y2,
    output logic                              done,
    output logic                              hit,
    output logic [1:0]                        case_code
);
    import sit_pkg::*;

    localparam int CW        = COORD_WIDTH;
    localparam int SH        = 32 - FRAC_BITS;
    localparam int IW1       = CW + 1;
    localparam int DIV1_LAT  = IW1 + QUOT_FRAC + 1;
    localparam int DIV2_LAT  = Q_W + QUOT_FRAC + 1;
    localparam int LATENCY   = 2 + DIV1_LAT + MUL_LAT + 3 + DIV2_LAT + 1;

    typedef struct packed {
        logic signed [CW-1:0] x1;
        logic signed [CW-1:0] y1;
        logic signed [CW-1:0] x2;
        logic signed [CW-1:0] y2;
        logic                 vert;
    } seg_t;

    typedef struct packed {
        seg_t                 seg;
        logic [CW:0]          dx;
        logic signed [CW:0]   dy;
    } nrm_t;

    typedef struct packed {
        seg_t f;
        seg_t s;
    } pair_t;

    typedef struct packed {
        pair_t              p;
        logic signed [63:0] a_f;
        logic signed [63:0] a_s;
    } mtag_t;

    typedef struct packed {
        case_code_t         code;
        logic               general;
        logic               pre_hit;
        logic signed [63:0] f_lo;
        logic signed [63:0] f_hi;
        logic signed [63:0] s_lo;
        logic signed [63:0] s_hi;
    } d2tag_t;

    function automatic logic signed [63:0] to_wide(input logic signed [CW-1:0] raw);
        logic [63+SH:0]     t;
        logic signed [63:0] r;
        t = {{(64+SH-CW){raw[CW-1]}}, raw} << SH;
        if ((&t[63+SH:63]) || !(|t[63+SH:63]))
        begin
            r = $signed(t[63:0]);
        end
        else
        begin
            r = raw[CW-1] ? W_MIN : W_MAX;
        end
        return r;
    endfunction

    function automatic nrm_t sort_x(input logic signed [CW-1:0] x1, input logic signed [CW-1:0] y1,
                                    input logic signed [CW-1:0] x2, input logic signed [CW-1:0] y2);
        nrm_t n;
        if (x1 < x2)
        begin
            n.seg.x1 = x1;
            n.seg.y1 = y1;
            n.seg.x2 = x2;
            n.seg.y2 = y2;
        end
        else
        begin
            n.seg.x1 = x2;
            n.seg.y1 = y2;
            n.seg.x2 = x1;
            n.seg.y2 = y1;
        end
        n.seg.vert = 1'b0;
        n.dx = {n.seg.x2[CW-1], n.seg.x2} - {n.seg.x1[CW-1], n.seg.x1};
        n.dy = {n.seg.y2[CW-1], n.seg.y2} - {n.seg.y1[CW-1], n.seg.y1};
        return n;
    endfunction

    function automatic nrm_t fix_vert(input nrm_t n, input logic [CW:0] tol);
        nrm_t o;
        o = n;
        o.seg.vert = (n.dx < tol) || (n.dx == '0);
        if (o.seg.vert && (n.seg.y1 > n.seg.y2))
        begin
            o.seg.x1 = n.seg.x2;
            o.seg.y1 = n.seg.y2;
            o.seg.x2 = n.seg.x1;
            o.seg.y2 = n.seg.y1;
        end
        return o;
    endfunction

    // configuration registers
    logic [TOL_W-1:0]           tol_reg;
    logic signed [MARGIN_W-1:0] margin_reg;
    logic                       cfg_wr;
    logic signed [63:0]         e_w;
    logic [CW:0]                tol_ext;

    assign pready  = 1'b1;
    assign busy    = 1'b0;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign e_w     = $signed({{(64-MARGIN_W){margin_reg[MARGIN_W-1]}}, margin_reg}) <<< SH;
    assign tol_ext = {{(CW+1-TOL_W){1'b0}}, tol_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg    <= TOL_RESET;
            margin_reg <= MARGIN_RESET;
        end
        else if (cfg_wr)
        begin
            case (reg_idx_t'(paddr[2:2]))
                REG_TOL:    tol_reg    <= pwdata[TOL_W-1:0];
                REG_MARGIN: margin_reg <= $signed(pwdata[MARGIN_W-1:0]);
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx_t'(paddr[2:2]))
            REG_TOL:    prdata = {{(DATA_W-TOL_W){1'b0}}, tol_reg};
            REG_MARGIN: prdata = {{(DATA_W-MARGIN_W){margin_reg[MARGIN_W-1]}}, margin_reg};
            default:    prdata = '0;
        endcase
    end

    // stage 1: order by x; stage 2: vertical class
    logic s1_v_reg;
    logic s2_v_reg;
    nrm_t s1_f_reg;
    nrm_t s1_s_reg;
    nrm_t s2_f_reg;
    nrm_t s2_s_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= start && !busy;
            s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_f_reg <= sort_x(first_x1, first_y1, first_x2, first_y2);
        s1_s_reg <= sort_x(second_x1, second_y1, second_x2, second_y2);
        s2_f_reg <= fix_vert(s1_f_reg, tol_ext);
        s2_s_reg <= fix_vert(s1_s_reg, tol_ext);
    end

    // slopes
    logic               d1_valid;
    logic signed [63:0] qf;
    logic signed [63:0] qs;
    pair_t              d1_tag_in;
    pair_t              d1_tag_out;

    assign d1_tag_in.f = s2_f_reg.seg;
    assign d1_tag_in.s = s2_s_reg.seg;

    sit_div #(
        .IW    (IW1),
        .TAG_W ($bits(pair_t))
    ) u_div_slope_f (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_v_reg),
        .num       (s2_f_reg.dy),
        .den       ($signed(s2_f_reg.dx)),
        .in_tag    (d1_tag_in),
        .out_valid (d1_valid),
        .quot      (qf),
        .out_tag   (d1_tag_out)
    );

    sit_div #(
        .IW    (IW1),
        .TAG_W (1)
    ) u_div_slope_s (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_v_reg),
        .num       (s2_s_reg.dy),
        .den       ($signed(s2_s_reg.dx)),
        .in_tag    (1'b0),
        .out_valid (),
        .quot      (qs),
        .out_tag   ()
    );

    // products for intercepts and for the other line at a vertical x
    mtag_t              m_tag_in;
    mtag_t              m_tag_out;
    logic               m_valid;
    logic signed [63:0] m_bf;
    logic signed [63:0] m_bs;
    logic signed [63:0] m_yf;
    logic signed [63:0] m_ys;

    assign m_tag_in.p   = d1_tag_out;
    assign m_tag_in.a_f = d1_tag_out.f.vert ? 64'sd0 : qf;
    assign m_tag_in.a_s = d1_tag_out.s.vert ? 64'sd0 : qs;

    sit_mul #(.AW(CW), .SH(FRAC_BITS), .TAG_W($bits(mtag_t))) u_mul_bf (
        .clk (clk), .rst_n (rst_n), .in_valid (d1_valid),
        .a (d1_tag_out.f.x1), .b (m_tag_in.a_f), .in_tag (m_tag_in),
        .out_valid (m_valid), .res (m_bf), .out_tag (m_tag_out)
    );

    sit_mul #(.AW(CW), .SH(FRAC_BITS), .TAG_W(1)) u_mul_bs (
        .clk (clk), .rst_n (rst_n), .in_valid (d1_valid),
        .a (d1_tag_out.s.x1), .b (m_tag_in.a_s), .in_tag (1'b0),
        .out_valid (), .res (m_bs), .out_tag ()
    );

    sit_mul #(.AW(CW), .SH(FRAC_BITS), .TAG_W(1)) u_mul_yf (
        .clk (clk), .rst_n (rst_n), .in_valid (d1_valid),
        .a (d1_tag_out.s.x1), .b (m_tag_in.a_f), .in_tag (1'b0),
        .out_valid (), .res (m_yf), .out_tag ()
    );

    sit_mul #(.AW(CW), .SH(FRAC_BITS), .TAG_W(1)) u_mul_ys (
        .clk (clk), .rst_n (rst_n), .in_valid (d1_valid),
        .a (d1_tag_out.f.x1), .b (m_tag_in.a_s), .in_tag (1'b0),
        .out_valid (), .res (m_ys), .out_tag ()
    );

    // stage p1: intercepts, bounds, slope difference
    logic               p1_v_reg;
    logic               p1_fv_reg;
    logic               p1_sv_reg;
    logic               p1_aeq_reg;
    logic signed [63:0] p1_bf_reg;
    logic signed [63:0] p1_bs_reg;
    logic signed [63:0] p1_myf_reg;
    logic signed [63:0] p1_mys_reg;
    logic signed [63:0] p1_den_reg;
    logic signed [63:0] p1_wfx_reg;
    logic signed [63:0] p1_wsx_reg;
    logic signed [63:0] p1_flo_reg;
    logic signed [63:0] p1_fhi_reg;
    logic signed [63:0] p1_slo_reg;
    logic signed [63:0] p1_shi_reg;
    logic signed [63:0] p1_fylo_reg;
    logic signed [63:0] p1_fyhi_reg;
    logic signed [63:0] p1_sylo_reg;
    logic signed [63:0] p1_syhi_reg;

    // stage p2: line values, crossing numerator, x range tests
    logic               p2_v_reg;
    logic               p2_fv_reg;
    logic               p2_sv_reg;
    logic               p2_aeq_reg;
    logic               p2_xinf_reg;
    logic               p2_xins_reg;
    logic signed [63:0] p2_ylf_reg;
    logic signed [63:0] p2_yls_reg;
    logic signed [63:0] p2_num_reg;
    logic signed [63:0] p2_den_reg;
    logic signed [63:0] p2_da_reg;
    logic signed [63:0] p2_flo_reg;
    logic signed [63:0] p2_fhi_reg;
    logic signed [63:0] p2_slo_reg;
    logic signed [63:0] p2_shi_reg;
    logic signed [63:0] p2_fylo_reg;
    logic signed [63:0] p2_fyhi_reg;
    logic signed [63:0] p2_sylo_reg;
    logic signed [63:0] p2_syhi_reg;

    // stage p3: class decision
    logic               p3_v_reg;
    d2tag_t             p3_tag_reg;
    logic signed [63:0] p3_num_reg;
    logic signed [63:0] p3_den_reg;

    logic       vhit_f;
    logic       vhit_s;
    logic       par;
    d2tag_t     p3_tag_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_v_reg <= 1'b0;
            p2_v_reg <= 1'b0;
            p3_v_reg <= 1'b0;
        end
        else
        begin
            p1_v_reg <= m_valid;
            p2_v_reg <= p1_v_reg;
            p3_v_reg <= p2_v_reg;
        end
    end

    always_comb
    begin
        vhit_f = p2_xinf_reg && (p2_ylf_reg > p2_fylo_reg) && (p2_ylf_reg < p2_fyhi_reg);
        vhit_s = p2_xins_reg && (p2_yls_reg > p2_sylo_reg) && (p2_yls_reg < p2_syhi_reg);
        par    = p2_da_reg < e_w;
        p3_tag_next.code    = p2_fv_reg ? CASE_FIRST_VERT :
                              (p2_sv_reg ? CASE_SECOND_VERT : CASE_GENERAL);
        p3_tag_next.general = !par && !p2_fv_reg && !p2_sv_reg && !p2_aeq_reg;
        if (par)
        begin
            p3_tag_next.pre_hit = 1'b0;
        end
        else if (p2_fv_reg)
        begin
            p3_tag_next.pre_hit = vhit_f;
        end
        else if (p2_sv_reg)
        begin
            p3_tag_next.pre_hit = vhit_s;
        end
        else
        begin
            p3_tag_next.pre_hit = 1'b0;
        end
        p3_tag_next.f_lo = p2_flo_reg;
        p3_tag_next.f_hi = p2_fhi_reg;
        p3_tag_next.s_lo = p2_slo_reg;
        p3_tag_next.s_hi = p2_shi_reg;
    end

    always_ff @(posedge clk)
    begin
        p1_fv_reg   <= m_tag_out.p.f.vert;
        p1_sv_reg   <= m_tag_out.p.s.vert;
        p1_aeq_reg  <= m_tag_out.a_f == m_tag_out.a_s;
        p1_bf_reg   <= sat_sub(to_wide(m_tag_out.p.f.y1), m_bf);
        p1_bs_reg   <= sat_sub(to_wide(m_tag_out.p.s.y1), m_bs);
        p1_myf_reg  <= m_yf;
        p1_mys_reg  <= m_ys;
        p1_den_reg  <= sat_sub(m_tag_out.a_f, m_tag_out.a_s);
        p1_wfx_reg  <= to_wide(m_tag_out.p.f.x1);
        p1_wsx_reg  <= to_wide(m_tag_out.p.s.x1);
        p1_flo_reg  <= sat_add(to_wide(m_tag_out.p.f.x1), e_w);
        p1_fhi_reg  <= sat_sub(to_wide(m_tag_out.p.f.x2), e_w);
        p1_slo_reg  <= sat_add(to_wide(m_tag_out.p.s.x1), e_w);
        p1_shi_reg  <= sat_sub(to_wide(m_tag_out.p.s.x2), e_w);
        p1_fylo_reg <= sat_add(to_wide(m_tag_out.p.f.y1), e_w);
        p1_fyhi_reg <= sat_sub(to_wide(m_tag_out.p.f.y2), e_w);
        p1_sylo_reg <= sat_add(to_wide(m_tag_out.p.s.y1), e_w);
        p1_syhi_reg <= sat_sub(to_wide(m_tag_out.p.s.y2), e_w);

        p2_fv_reg   <= p1_fv_reg;
        p2_sv_reg   <= p1_sv_reg;
        p2_aeq_reg  <= p1_aeq_reg;
        p2_xinf_reg <= (p1_wfx_reg > p1_slo_reg) && (p1_wfx_reg < p1_shi_reg);
        p2_xins_reg <= (p1_wsx_reg > p1_flo_reg) && (p1_wsx_reg < p1_fhi_reg);
        p2_ylf_reg  <= sat_add(p1_bs_reg, p1_mys_reg);
        p2_yls_reg  <= sat_add(p1_bf_reg, p1_myf_reg);
        p2_num_reg  <= sat_sub(p1_bs_reg, p1_bf_reg);
        p2_den_reg  <= p1_den_reg;
        p2_da_reg   <= abs_sat(p1_den_reg);
        p2_flo_reg  <= p1_flo_reg;
        p2_fhi_reg  <= p1_fhi_reg;
        p2_slo_reg  <= p1_slo_reg;
        p2_shi_reg  <= p1_shi_reg;
        p2_fylo_reg <= p1_fylo_reg;
        p2_fyhi_reg <= p1_fyhi_reg;
        p2_sylo_reg <= p1_sylo_reg;
        p2_syhi_reg <= p1_syhi_reg;

        p3_tag_reg  <= p3_tag_next;
        p3_num_reg  <= p2_num_reg;
        p3_den_reg  <= p2_den_reg;
    end

    // crossing x
    logic               d2_valid;
    logic signed [63:0] xq;
    d2tag_t             d2_tag_out;

    sit_div #(
        .IW    (Q_W),
        .TAG_W ($bits(d2tag_t))
    ) u_div_cross (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (p3_v_reg),
        .num       (p3_num_reg),
        .den       (p3_den_reg),
        .in_tag    (p3_tag_reg),
        .out_valid (d2_valid),
        .quot      (xq),
        .out_tag   (d2_tag_out)
    );

    // result word
    logic       done_reg;
    logic       hit_reg;
    case_code_t code_reg;
    logic       ghit;

    assign ghit = (xq > d2_tag_out.f_lo) && (xq < d2_tag_out.f_hi) &&
                  (xq > d2_tag_out.s_lo) && (xq < d2_tag_out.s_hi);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= d2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg  <= d2_tag_out.general ? ghit : d2_tag_out.pre_hit;
        code_reg <= d2_tag_out.code;
    end

    assign done      = done_reg;
    assign hit       = hit_reg;
    assign case_code = code_reg;

    `SIT_ASSERT_IMPL(a_done_latency, clk, rst_n, done, $past(start && !busy, LATENCY), "done without matching start")
    `SIT_ASSERT_NEXT(a_accept_enters, clk, rst_n, start && !busy, s1_v_reg, "accepted word lost at entry")
    `SIT_ASSERT_IMPL(a_general_code, clk, rst_n, d2_valid && d2_tag_out.general, d2_tag_out.code == CASE_GENERAL, "crossing path with vertical class")

endmodule

`default_nettype wire

// ===== tb/tb_segment_intersection_test_unit.sv =====
// self-checking testbench for the segment intersection test unit
// depends on sit_pkg and segment_intersection_test_unit; carries its own q32.32 predictor
`timescale 1ns / 1ps
`default_nettype none

module tb_segment_intersection_test_unit;
    import sit_pkg::*;

    localparam int CW = 32;
    localparam int FB = 16;
    localparam int PIPE_LAT = CW + 141;
    localparam logic signed [63:0] QMAX = 64'sh7fff_ffff_ffff_ffff;
    localparam logic signed [63:0] QMIN = 64'sh8000_0000_0000_0000;

    typedef struct {
        logic signed [63:0] x1, y1, x2, y2, a, b;
        logic vert;
    } seg_t;

    typedef struct {
        logic hit;
        case_code_t code;
    } verdict_t;

    typedef struct {
        logic signed [CW-1:0] c [8];
        logic has_ref;
        verdict_t ref_val;
    } pair_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic pready;
    logic start = 1'b0;
    logic busy;
    logic signed [CW-1:0] coord [8];
    logic done, hit;
    logic [1:0] case_code;

    logic [15:0] tol_shadow;
    logic signed [17:0] margin_shadow;
    verdict_t verdict_q [$];
    int mismatches = 0;
    int send_idle_pct = 0;
    pair_row_t rows [$];

    always #4 clk = ~clk;

    segment_intersection_test_unit dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .start(start), .busy(busy),
        .first_x1(coord[0]), .first_y1(coord[1]), .first_x2(coord[2]), .first_y2(coord[3]),
        .second_x1(coord[4]), .second_y1(coord[5]), .second_x2(coord[6]),
        .second_y2(coord[7]),
        .done(done), .hit(hit), .case_code(case_code)
    );

    initial
    begin
        for (int i = 0; i < 8; i++)
        begin
            coord[i] = '0;
        end
    end

    function automatic logic signed [63:0] q_add(logic signed [63:0] a, logic signed [63:0] b);
        logic signed [64:0] t;
        t = a + b;
        return (t > QMAX) ? QMAX : (t < QMIN) ? QMIN : t[63:0];
    endfunction

    function automatic logic signed [63:0] q_sub(logic signed [63:0] a, logic signed [63:0] b);
        logic signed [64:0] t;
        t = a - b;
        return (t > QMAX) ? QMAX : (t < QMIN) ? QMIN : t[63:0];
    endfunction

    function automatic logic signed [63:0] widen(logic signed [63:0] raw);
        logic signed [127:0] t;
        t = raw <<< (32 - FB);
        return (t > QMAX) ? QMAX : (t < QMIN) ? QMIN : t[63:0];
    endfunction

    function automatic logic signed [63:0] clamp(logic signed [129:0] v);
        return (v > QMAX) ? QMAX : (v < QMIN) ? QMIN : v[63:0];
    endfunction

    // truncating signed division keeps toward-zero rounding
    function automatic logic signed [63:0] mul_sh(logic signed [63:0] a, logic signed [63:0] b);
        logic signed [129:0] p;
        p = a * b;
        p = p / (130'sd1 <<< FB);
        return clamp(p);
    endfunction

    function automatic logic signed [63:0] div_q32(logic signed [63:0] n, logic signed [63:0] d);
        logic signed [129:0] p;
        if (d == 0)
        begin
            return 0;
        end
        p = n;
        p = (p <<< 32) / d;
        return clamp(p);
    endfunction

    function automatic seg_t build_seg(logic signed [63:0] px1, logic signed [63:0] py1,
                                       logic signed [63:0] px2, logic signed [63:0] py2);
        seg_t s;
        logic signed [63:0] dx, t;
        if (px1 < px2)
        begin
            s.x1 = px1; s.y1 = py1; s.x2 = px2; s.y2 = py2;
        end
        else
        begin
            s.x1 = px2; s.y1 = py2; s.x2 = px1; s.y2 = py1;
        end
        dx = s.x2 - s.x1;
        s.vert = (dx < $signed({48'd0, tol_shadow})) || (dx == 0);
        if (s.vert)
        begin
            if (s.y1 > s.y2)
            begin
                t = s.x1; s.x1 = s.x2; s.x2 = t;
                t = s.y1; s.y1 = s.y2; s.y2 = t;
            end
            s.a = 0;
        end
        else
        begin
            s.a = div_q32(s.y2 - s.y1, dx);
        end
        s.b = q_sub(widen(s.y1), mul_sh(s.x1, s.a));
        return s;
    endfunction

    function automatic logic strictly_in(logic signed [63:0] v, logic signed [63:0] lo,
                                         logic signed [63:0] hi, logic signed [63:0] e);
        return (v > q_add(lo, e)) && (v < q_sub(hi, e));
    endfunction

    function automatic logic upright_hit(seg_t s, seg_t o, logic signed [63:0] e);
        logic signed [63:0] x, y, ya, yb, ylo, yhi;
        x = widen(s.x1);
        y = q_add(o.b, mul_sh(s.x1, o.a));
        ya = widen(s.y1);
        yb = widen(s.y2);
        ylo = (ya < yb) ? ya : yb;
        yhi = (ya < yb) ? yb : ya;
        return strictly_in(x, widen(o.x1), widen(o.x2), e) && strictly_in(y, ylo, yhi, e);
    endfunction

    function automatic logic signed [63:0] abs_sat_local(logic signed [63:0] v);
        return (v == QMIN) ? QMAX : (v < 0) ? -v : v;
    endfunction

    function automatic verdict_t predict_crossing(logic signed [CW-1:0] c [8]);
        seg_t f, s;
        logic signed [63:0] e, da, x;
        verdict_t v;
        f = build_seg(c[0], c[1], c[2], c[3]);
        s = build_seg(c[4], c[5], c[6], c[7]);
        e = widen(margin_shadow);
        v.code = f.vert ? CASE_FIRST_VERT : (s.vert ? CASE_SECOND_VERT : CASE_GENERAL);
        da = abs_sat_local(q_sub(f.a, s.a));
        if (da < e)
        begin
            v.hit = 1'b0;
        end
        else if (f.vert)
        begin
            v.hit = upright_hit(f, s, e);
        end
        else if (s.vert)
        begin
            v.hit = upright_hit(s, f, e);
        end
        else if (f.a == s.a)
        begin
            v.hit = 1'b0;
        end
        else
        begin
            x = div_q32(q_sub(s.b, f.b), q_sub(f.a, s.a));
            v.hit = strictly_in(x, widen(f.x1), widen(f.x2), e)
                    && strictly_in(x, widen(s.x1), widen(s.x2), e);
        end
        return v;
    endfunction

    always @(posedge clk)
    begin
        verdict_t exp_v;
        if (rst_n && done)
        begin
            if (verdict_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: hit=%0d case=%0d", hit, case_code);
            end
            else
            begin
                exp_v = verdict_q.pop_front();
                if (hit !== exp_v.hit || case_code !== exp_v.code)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: hit exp %0d got %0d, case exp %0d got %0d",
                                 exp_v.hit, hit, exp_v.code, case_code);
                end
            end
        end
    end

    task automatic write_reg(reg_idx_t idx, logic [DATA_W-1:0] value);
        @(negedge clk);
        psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
        paddr = ADDR_W'(4 * int'(idx)); pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        if (idx == REG_TOL)
            tol_shadow = value[15:0];
        else
            margin_shadow = value[17:0];
    endtask

    task automatic drain();
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (PIPE_LAT + 10) @(posedge clk);
    endtask

    // start stays high after acceptance; an idle cycle or the caller lowers it
    task automatic send_pair(logic signed [CW-1:0] c [8], logic has_ref, verdict_t ref_val);
        verdict_t v;
        while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct)
        begin
            @(negedge clk);
            start = 1'b0;
        end
        @(negedge clk);
        for (int i = 0; i < 8; i++)
            coord[i] = c[i];
        start = 1'b1;
        do @(posedge clk); while (busy);
        v = predict_crossing(c);
        if (has_ref && (v.hit !== ref_val.hit || v.code !== ref_val.code))
            $display("table row disagrees with predictor: hit %0d/%0d", ref_val.hit, v.hit);
        verdict_q.push_back(has_ref ? ref_val : v);
    endtask

    function automatic logic signed [CW-1:0] rnd_coord(int mode);
        case (mode)
            0: return $signed($urandom());
            1: return $signed(32'($urandom_range(2000, 0)) - 32'sd1000) <<< 16;
            2: return $signed(32'($urandom_range(60, 0)) - 32'sd30) <<< 16;
            default: return $signed(32'($urandom_range(8, 0)) - 32'sd4);
        endcase
    endfunction

    task automatic add_row(int v0, int v1, int v2, int v3, int v4, int v5, int v6, int v7,
                           logic has_ref, logic h, case_code_t code);
        pair_row_t r;
        r.c[0] = v0; r.c[1] = v1; r.c[2] = v2; r.c[3] = v3;
        r.c[4] = v4; r.c[5] = v5; r.c[6] = v6; r.c[7] = v7;
        r.has_ref = has_ref;
        r.ref_val.hit = h;
        r.ref_val.code = code;
        rows.push_back(r);
    endtask

    localparam int ONE = 65536;
    localparam int XMX = 32'h7fff_ffff;
    localparam int XMN = 32'h8000_0000;

    initial
    begin
        logic signed [CW-1:0] c [8];
        verdict_t none;
        int mode, phase_items;
        none.hit = 1'b0;
        none.code = CASE_GENERAL;
        tol_shadow = TOL_RESET;
        margin_shadow = MARGIN_RESET;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // crossing diagonals, touching, parallel, verticals, extremes
        add_row(0, 0, 10*ONE, 10*ONE, 0, 10*ONE, 10*ONE, 0, 1'b1, 1'b1, CASE_GENERAL);
        add_row(0, 0, ONE, 0, 0, ONE, ONE, ONE, 1'b1, 1'b0, CASE_GENERAL);
        add_row(5*ONE, -5*ONE, 5*ONE, 5*ONE, 0, 0, 10*ONE, 0, 1'b1, 1'b1, CASE_FIRST_VERT);
        add_row(0, 0, 10*ONE, 0, 5*ONE, 5*ONE, 5*ONE, -5*ONE, 1'b1, 1'b1, CASE_SECOND_VERT);
        add_row(0, 0, 0, ONE, 2*ONE, 0, 2*ONE, ONE, 1'b1, 1'b0, CASE_FIRST_VERT);
        add_row(10*ONE, 10*ONE, 0, 0, 10*ONE, 0, 0, 10*ONE, 0, 0, CASE_GENERAL);
        add_row(0, 0, 10*ONE, 10*ONE, 10*ONE, 10*ONE, 20*ONE, 0, 0, 0, CASE_GENERAL);
        add_row(XMN, XMN, XMX, XMX, XMN, XMX, XMX, XMN, 0, 0, CASE_GENERAL);
        add_row(XMX, XMN, XMX, XMX, XMN, 0, XMX, 0, 0, 0, CASE_GENERAL);
        add_row(XMN, XMX, XMN + 1, XMN, 0, 0, XMX, XMX, 0, 0, CASE_GENERAL);
        add_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, CASE_GENERAL);
        add_row(-1, -1, -1, -1, -1, -1, -1, -1, 0, 0, CASE_GENERAL);
        add_row(3, XMN, 3, XMX, XMN, 0, XMX, 5, 0, 0, CASE_GENERAL);
        add_row(0, 0, 1, XMX, 0, XMX, 1, 0, 0, 0, CASE_GENERAL);
        add_row(XMN, 0, XMX, 1, XMN, 1, XMX, 0, 0, 0, CASE_GENERAL);

        foreach (rows[i])
            send_pair(rows[i].c, rows[i].has_ref, rows[i].ref_val);
        @(negedge clk);
        start = 1'b0;
        drain();

        for (int p = 0; p < 5; p++)
        begin
            case (p)
                0: begin write_reg(REG_TOL, 0); write_reg(REG_MARGIN, 32'(-65536)); end
                1: begin write_reg(REG_TOL, 65535); write_reg(REG_MARGIN, 65536); end
                2: begin write_reg(REG_TOL, 1); write_reg(REG_MARGIN, 0); end
                3: begin write_reg(REG_TOL, $urandom_range(65535, 0));
                         write_reg(REG_MARGIN, 32'($urandom_range(131072, 0)) - 65536); end
                default: begin write_reg(REG_TOL, TOL_RESET); write_reg(REG_MARGIN, 32'(-1)); end
            endcase
            phase_items = 250;
            for (int n = 0; n < phase_items; n++)
            begin
                send_idle_pct = (n < 84) ? 15 : (n < 168) ? 74 : 0;
                mode = $urandom_range(3, 0);
                for (int i = 0; i < 8; i++)
                    c[i] = rnd_coord(mode);
                if ($urandom_range(4, 0) == 0)
                    c[2] = c[0] + $signed(32'($urandom_range(3, 0)));
                if ($urandom_range(4, 0) == 0)
                    c[6] = c[4] - $signed(32'($urandom_range(3, 0)));
                send_pair(c, 1'b0, none);
            end
            @(negedge clk);
            start = 1'b0;
            drain();
        end

        if (mismatches == 0 && verdict_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire
